// File: hdl/tip_pkg.sv
`timescale 1ns / 1ps

package tip_pkg;

  // operation codes carried in in_tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_STEP_LENGTH    = 2'd0;
  localparam logic [1:0] CFG_INTERP_MODE    = 2'd1;
  localparam logic [1:0] CFG_ENTRIES_IN_USE = 2'd2;

  localparam logic [31:0] STEP_RESET    = 32'h0001_0000;
  localparam logic        MODE_RESET    = 1'b1;
  localparam logic [10:0] ENTRIES_RESET = 11'd1024;

  localparam logic MODE_CONST  = 1'b0;
  localparam logic MODE_LINEAR = 1'b1;

  // 32 integer quotient bits, then 16 fraction bits for the blend weight
  localparam int DIV_STEPS = 48;
  localparam int FRAC_BITS = 16;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [31:0] step_length;
    logic        interp_mode;
    logic [10:0] entries_in_use;
  } cfg_t;

  // classified word handed from front to back
  typedef struct packed {
    logic        is_query;
    logic        t_pos;     // query time above zero
    logic        wr_ok;     // write index inside the table
    logic [9:0]  idx;
    logic [31:0] data;      // sample for a write, time for a query
  } cmd_t;

endpackage

// File: hdl/table_interpolator_core.sv
`timescale 1ns / 1ps

// Uniform-grid table interpolator. Write words (in_tuser = 0) store one signed Q16.16
// sample and are retired by the back end straight from its idle state, so a burst of
// writes streams at one word per cycle while the back end is idle. Query words
// (in_tuser = 1) divide the time by step_length in a radix-2 serial divider of 48 steps
// (32 quotient bits plus 16 weight bits); a check state then reads one entry, or, in
// linear mode inside the table, two entries blended by a multiply and a rounded sum.
// A query whose time is at or below zero, or whose step is zero, skips the divider. A
// two-word queue sits between the input stage and the divider, so input is still
// accepted while a query is in work until the queue fills. Reading a table entry that
// was never written returns an undefined value; there is no clearing pass.
module table_interpolator_core #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // entry_index[9:0], entry_value[41:10], query_time[73:42]
  input  logic        in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // interpolated_value[31:0]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import tip_pkg::*;

  cfg_t cfg_r;
  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_length    <= STEP_RESET;
      cfg_r.interp_mode    <= MODE_RESET;
      cfg_r.entries_in_use <= ENTRIES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STEP_LENGTH:    cfg_r.step_length    <= cfg_wdata;
        CFG_INTERP_MODE:    cfg_r.interp_mode    <= cfg_wdata[0];
        CFG_ENTRIES_IN_USE: cfg_r.entries_in_use <= cfg_wdata[10:0];
        default:            cfg_r <= cfg_r;
      endcase
    end
  end

  tip_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_tuser),
    .in_idx     (in_tdata[9:0]),
    .in_value   (in_tdata[41:10]),
    .in_time    (in_tdata[73:42]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  tip_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  tip_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

// File: hdl/tip_front.sv
`timescale 1ns / 1ps

module tip_front #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_op,
  input  logic [9:0]    in_idx,
  input  logic [31:0]   in_value,
  input  logic [31:0]   in_time,
  output logic          push_valid,
  input  logic          push_ready,
  output tip_pkg::cmd_t push_cmd
);
  import tip_pkg::*;

  logic vld_r;
  cmd_t cmd_r;
  cmd_t cmd_nxt;

  assign in_ready = !vld_r || push_ready;

  always_comb begin
    cmd_nxt.is_query = (in_op == OP_QUERY);
    cmd_nxt.t_pos    = !in_time[31] && (in_time != 32'd0);
    cmd_nxt.wr_ok    = ({22'd0, in_idx} < 32'(TABLE_DEPTH));
    cmd_nxt.idx      = in_idx;
    cmd_nxt.data     = (in_op == OP_QUERY) ? in_time : in_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign push_valid = vld_r;
  assign push_cmd   = cmd_r;

endmodule

// File: hdl/tip_queue.sv
`timescale 1ns / 1ps

module tip_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  tip_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop,
  output tip_pkg::cmd_t pop_cmd
);
  import tip_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [PW:0]   count_r;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count_r != (PW+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_cmd    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: hdl/tip_back.sv
`timescale 1ns / 1ps

module tip_back #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  tip_pkg::cfg_t cfg,
  input  logic          q_valid,
  input  tip_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   out_data
);
  import tip_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_CHK, S_RDA, S_RDB, S_MUL, S_SUM, S_FIN, S_OUT
  } state_t;

  state_t state_r;

  logic [31:0] mem [TABLE_DEPTH];
  logic [31:0] rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          wr_en;

  logic [31:0]          dvd_r;
  logic [31:0]          rem_r;
  logic [DIV_STEPS-1:0] quo_r;
  logic [CW-1:0]        cnt_r;
  logic [31:0]          y0_r;
  logic [31:0]          y1_r;
  logic signed [49:0]   prod_r;
  logic [31:0]          res_r;
  logic                 out_vld_r;
  logic [31:0]          out_data_r;

  logic [32:0]          rem2;
  logic [32:0]          rem_sub;
  logic                 qbit;
  logic [31:0]          rem_nxt;
  logic [AW-1:0]        last;
  logic [31:0]          quot;
  logic [FRAC_BITS-1:0] wgt;
  logic [AW-1:0]        q_lo;
  logic                 beyond;
  logic signed [32:0]   diff;
  logic signed [49:0]   sum;

  // last valid index from the entry count, clamped to the table
  always_comb begin
    if ({21'd0, cfg.entries_in_use} > 32'(TABLE_DEPTH)) begin
      last = AW'(TABLE_DEPTH - 1);
    end else if (cfg.entries_in_use == 11'd0) begin
      last = '0;
    end else begin
      last = AW'(cfg.entries_in_use - 11'd1);
    end
  end

  // one restoring step; zeros shift in after the dividend for the weight bits
  assign rem2    = {rem_r, dvd_r[31]};
  assign rem_sub = rem2 - {1'b0, cfg.step_length};
  assign qbit    = !rem_sub[32];
  assign rem_nxt = qbit ? rem_sub[31:0] : rem2[31:0];

  assign quot   = quo_r[DIV_STEPS-1 -: 32];
  assign wgt    = quo_r[FRAC_BITS-1:0];
  assign q_lo   = quot[AW-1:0];
  assign beyond = (quot >= 32'(last));

  assign diff = $signed({y1_r[31], y1_r}) - $signed({y0_r[31], y0_r});
  assign sum  = $signed({{2{y0_r[31]}}, y0_r, 16'd0}) + prod_r + 50'sd32768;

  assign q_pop = (state_r == S_IDLE) && q_valid;
  assign wr_en = q_pop && !q_cmd.is_query && q_cmd.wr_ok;

  always_comb begin
    case (state_r)
      S_IDLE:  rd_addr = q_cmd.t_pos ? last : '0;
      S_CHK: begin
        if (beyond) begin
          rd_addr = last;
        end else if (cfg.interp_mode == MODE_LINEAR) begin
          rd_addr = q_lo;
        end else begin
          rd_addr = q_lo + 1'b1;
        end
      end
      S_RDA:   rd_addr = q_lo + 1'b1;
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(q_cmd.idx)] <= q_cmd.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      // S_OUT handles the output register itself
      if (out_vld_r && out_ready && state_r != S_OUT) begin
        out_vld_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid && q_cmd.is_query) begin
            if (!q_cmd.t_pos || cfg.step_length == 32'd0) begin
              state_r <= S_FIN;
            end else begin
              dvd_r   <= q_cmd.data;
              rem_r   <= '0;
              cnt_r   <= '0;
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          dvd_r <= {dvd_r[30:0], 1'b0};
          rem_r <= rem_nxt;
          quo_r <= {quo_r[DIV_STEPS-2:0], qbit};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(DIV_STEPS - 1)) begin
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (beyond || cfg.interp_mode == MODE_CONST) begin
            state_r <= S_FIN;
          end else begin
            state_r <= S_RDA;
          end
        end
        S_RDA: begin
          y0_r    <= rd_data_r;
          state_r <= S_RDB;
        end
        S_RDB: begin
          y1_r    <= rd_data_r;
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= 50'(diff) * 50'($signed({1'b0, wgt}));
          state_r <= S_SUM;
        end
        S_SUM: begin
          res_r   <= sum[47:16];
          state_r <= S_OUT;
        end
        S_FIN: begin
          res_r   <= rd_data_r;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_vld_r || out_ready) begin
            out_vld_r  <= 1'b1;
            out_data_r <= res_r;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import tip_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam int RANDOM_PHASES = 8;
  localparam int WORDS_PER_PHASE = 205;
  localparam int SETTLE_CYCLES = 80;
  localparam int CYCLE_LIMIT = 1000000;
  // register index past the end of the map, must be ignored
  localparam logic [1:0] CFG_UNMAPPED = 2'd3;

  typedef struct {
    logic        op;
    logic [9:0]  idx;
    logic [31:0] value;
    logic [31:0] qtime;
  } table_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  // mirror of the block's settings and table
  logic [31:0] step_mirror = STEP_RESET;
  logic        mode_mirror = MODE_RESET;
  logic [10:0] ent_mirror = ENTRIES_RESET;
  logic [31:0] sample_mirror [TABLE_DEPTH];

  bit          written_gen [TABLE_DEPTH];
  table_word_t pending_words[$];
  logic [31:0] expected_values[$];
  table_word_t cur_word;

  int words_pushed = 0;
  int words_accepted = 0;
  int queries_accepted = 0;
  int results_checked = 0;
  int settings_used = 0;
  int errors = 0;
  int burst_left = 0;
  int gap_left = 0;
  int cycles = 0;
  int rx_style = 0;
  int rx_hold = 0;

  table_interpolator_core #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic longint last_entry();
    longint n;
    n = ent_mirror;
    if (n == 0) n = 1;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    return n - 1;
  endfunction

  // Entries read for time t, plus the Q0.16 weight of the upper one.
  function automatic void grid_locate(input logic [31:0] t, output int lo, output int hi,
                                      output longint wt);
    longint last, tq, s, q, r;
    last = last_entry();
    tq = longint'($signed(t));
    s = {32'd0, step_mirror};
    wt = 0;
    if (tq <= 0) begin
      lo = 0;
      hi = 0;
    end else if (s == 0) begin
      lo = int'(last);
      hi = int'(last);
    end else begin
      q = tq / s;
      r = tq % s;
      if (q >= last) begin
        lo = int'(last);
        hi = int'(last);
      end else if (mode_mirror == MODE_CONST) begin
        lo = int'(q + 1);
        hi = int'(q + 1);
      end else begin
        lo = int'(q);
        hi = int'(q + 1);
        wt = (r * 65536) / s;
      end
    end
  endfunction

  function automatic logic [31:0] interp_at(input logic [31:0] t);
    int lo, hi;
    longint wt, y0, y1, acc;
    grid_locate(t, lo, hi, wt);
    y0 = longint'($signed(sample_mirror[lo]));
    y1 = longint'($signed(sample_mirror[hi]));
    acc = y0 * (65536 - wt) + y1 * wt;
    return 32'((acc + 32768) >>> 16);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch @%0t: %s got %h want %h", $time, what, got, want);
    errors++;
  endtask

  // driver: bursts of words with random gaps
  always @(posedge clk) begin : drive_words
    logic fire;
    fire = in_tvalid && in_tready;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || fire) begin
      if (fire) begin
        words_accepted++;
        if (cur_word.op == OP_WRITE) begin
          sample_mirror[cur_word.idx] = cur_word.value;
        end else begin
          queries_accepted++;
          expected_values.insert(expected_values.size(), interp_at(cur_word.qtime));
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        cur_word = pending_words.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {6'd0, cur_word.qtime, cur_word.value, cur_word.idx};
        in_tuser <= cur_word.op;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left--;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result check
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_values.size() == 0) begin
        report_mismatch("result word with nothing pending", out_tdata, 32'h0);
      end else begin
        results_checked++;
        if (out_tdata !== expected_values[0])
          report_mismatch("interpolated_value", out_tdata, expected_values[0]);
        void'(expected_values.pop_front());
      end
    end
  end

  // receiver back-pressure, in a style drawn anew at random from four; also the timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      if (cycles % 256 == 0) rx_style = $urandom_range(0, 3);
      case (rx_style)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= (cycles % 7) >= 3;
        default: begin
          if (rx_hold > 0) begin
            rx_hold--;
            out_tready <= 1'b0;
          end else if ($urandom_range(0, 15) == 0) begin
            rx_hold = $urandom_range(5, 20);
            out_tready <= 1'b0;
          end else begin
            out_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_write(input int idx, input logic [31:0] value);
    table_word_t w;
    w.op = OP_WRITE;
    w.idx = 10'(idx);
    w.value = value;
    w.qtime = $urandom;
    written_gen[idx] = 1'b1;
    pending_words.insert(pending_words.size(), w);
    words_pushed++;
  endtask

  // a query never reads an entry that was not loaded first
  task automatic push_query(input logic [31:0] t);
    table_word_t w;
    int lo, hi;
    longint wt;
    grid_locate(t, lo, hi, wt);
    if (!written_gen[lo]) push_write(lo, rand_sample());
    if (!written_gen[hi]) push_write(hi, rand_sample());
    w.op = OP_QUERY;
    w.idx = 10'($urandom);
    w.value = $urandom;
    w.qtime = t;
    pending_words.insert(pending_words.size(), w);
    words_pushed++;
  endtask

  // time landing on the grid inside the table
  function automatic logic [31:0] grid_time();
    longint last, s, qmax, q, base, room;
    last = last_entry();
    s = {32'd0, step_mirror};
    if (last == 0 || s == 0) return $urandom_range(0, 32'h7FFF_FFFF);
    qmax = 64'h7FFF_FFFF / s;
    if (qmax > last) qmax = last;
    q = $urandom_range(0, 32'(qmax));
    base = q * s;
    room = 64'h7FFF_FFFF - base;
    if (room >= s) room = s - 1;
    case ($urandom_range(0, 9))
      0: return 32'(base);
      1: return 32'(base + room);
      default: return 32'(base + ($urandom % (room + 1)));
    endcase
  endfunction

  task automatic wait_idle();
    while (words_accepted != words_pushed || expected_values.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_STEP_LENGTH:    step_mirror = value;
      CFG_INTERP_MODE:    mode_mirror = value[0];
      CFG_ENTRIES_IN_USE: ent_mirror = value[10:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] step, input logic mode, input logic [10:0] n);
    wait_idle();
    cfg_write(CFG_STEP_LENGTH, step);
    cfg_write(CFG_INTERP_MODE, {31'd0, mode});
    cfg_write(CFG_ENTRIES_IN_USE, {21'd0, n});
    settings_used++;
  endtask

  initial begin
    logic [31:0] step;
    logic        mode;
    logic [10:0] n;
    int          phase_stop;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: step 1.0, linear, full table
    push_write(0, 32'h7FFF_FFFF);
    push_write(1, 32'h8000_0000);
    push_write(1023, 32'hFFFF_FFFF);
    push_write(2, 32'h0);
    push_query(32'h0);
    push_query(32'hFFFF_FFFF);
    push_query(32'h8000_0000);
    push_query(32'h0000_0001);
    push_query(32'h0000_8000);      // half way, rounds up
    push_query(32'h0001_FFFF);
    push_query(32'h7FFF_FFFF);      // past the end
    push_query(32'h03FF_0000);      // exactly on the last entry
    push_query(32'h03FE_FFFF);      // last interior pair

    set_config(STEP_RESET, MODE_CONST, ENTRIES_RESET);
    push_query(32'h0000_0001);
    push_query(32'h0001_0000);

    // zero step skips the divider and reads the last entry for a time above zero
    set_config(32'h0, MODE_LINEAR, 11'd16);
    push_query(32'h0000_0001);
    push_query(32'h0);

    // zero entry count acts as one entry
    set_config(STEP_RESET, MODE_LINEAR, 11'd0);
    push_query(32'h7FFF_FFFF);
    push_query(32'h0000_8000);

    // oversize entry count clamps to the table depth
    set_config(32'h0000_0001, MODE_LINEAR, 11'd2047);
    push_query(32'h7FFF_FFFF);
    push_query(32'h0000_03FE);

    set_config(32'hFFFF_FFFF, MODE_LINEAR, 11'd2);
    push_query(32'h7FFF_FFFF);
    push_query(32'h4000_0000);

    // write to an unmapped register must change nothing
    wait_idle();
    cfg_write(CFG_UNMAPPED, $urandom);
    push_query(32'h7FFF_FFFF);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 9))
        0: step = 32'h0000_0001;
        1: step = 32'hFFFF_FFFF;
        2: step = 32'h0;
        3, 4: step = STEP_RESET;
        5, 6: step = $urandom_range(1, 32'h0004_0000);
        default: step = $urandom;
      endcase
      case ($urandom_range(0, 7))
        0: n = 11'd1;
        1: n = 11'd2;
        2: n = 11'd0;
        3: n = 11'd2047;
        4: n = 11'd1024;
        default: n = 11'($urandom_range(3, 1023));
      endcase
      mode = 1'($urandom_range(0, 1));
      set_config(step, mode, n);
      // loads a query pulls in count toward the phase budget
      phase_stop = words_pushed + WORDS_PER_PHASE;
      while (words_pushed < phase_stop) begin
        if ($urandom_range(0, 4) == 0)
          push_write($urandom_range(0, TABLE_DEPTH - 1), rand_sample());
        else if ($urandom_range(0, 3) == 0)
          push_query($urandom);
        else
          push_query(grid_time());
      end
    end

    wait_idle();
    while (expected_values.size() != 0) begin
      report_mismatch("result word never came", 32'h0, expected_values[0]);
      void'(expected_values.pop_front());
    end
    $display("%0d words sent, %0d of them queries; %0d results checked", words_accepted,
             queries_accepted, results_checked);
    $display("%0d register settings, %0d mismatches", settings_used, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/tip_pkg.sv
hdl/tip_front.sv
hdl/tip_queue.sv
hdl/tip_back.sv
hdl/table_interpolator_core.sv
verif/tb.sv
